@@ rtl/fprls_pkg.sv @@
// Shared types, constants and the line-select step function for the framed
// packet relay. No dependencies; used by every module of the block.
package fprls_pkg;

    localparam int unsigned MAX_FRAME_DEF = 11;
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic [7:0]  START_BYTE    = 8'h3A;
    localparam logic [7:0]  MASTER_ID     = 8'h73;
    localparam logic [7:0]  TIMEOUT_ID    = 8'h78;
    localparam logic [7:0]  TIMEOUT_LEN   = 8'd3;
    localparam logic [7:0]  MIN_LEN       = 8'd2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd60000;

    // Register word index
    localparam logic REG_TIMEOUT = 1'b0;

    // Event kinds
    localparam logic [1:0] KIND_RX     = 2'd0;
    localparam logic [1:0] KIND_TXDONE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Line-select machine states
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ONE   = 2'd1;
    localparam logic [1:0] MODE_TWO   = 2'd2;
    localparam logic [1:0] MODE_THREE = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] pins;
    } t_sel;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] line_select;
        logic [1:0] relay_mode;
    } t_result;

    function automatic t_sel advance_sel(input logic [1:0] mode, input logic master);
        t_sel s;
        unique case (mode)
            MODE_IDLE: begin
                if (master) begin
                    s.mode = MODE_ONE;
                    s.pins = 2'b01;
                end else begin
                    s.mode = MODE_THREE;
                    s.pins = 2'b11;
                end
            end
            MODE_ONE: begin
                s.mode = MODE_IDLE;
                s.pins = 2'b00;
            end
            MODE_TWO: begin
                s.mode = MODE_ONE;
                s.pins = 2'b01;
            end
            default: begin
                s.mode = MODE_TWO;
                s.pins = 2'b10;
            end
        endcase
        return s;
    endfunction

endpackage

@@ rtl/fprls_cfg.sv @@
// APB-style register port holding the timeout tick limit.
// Depends on fprls_pkg.
module fprls_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fprls_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fprls_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fprls_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [15:0]                         o_timeout_ticks
);
    import fprls_pkg::*;

    logic [15:0] r_timeout;
    logic        sel_timeout;

    assign sel_timeout = (paddr[2] == REG_TIMEOUT);
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && sel_timeout) begin
            r_timeout <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_timeout) begin
            prdata = {{(CFG_DATA_W-16){1'b0}}, r_timeout};
        end
    end

    assign o_timeout_ticks = r_timeout;

endmodule

@@ rtl/fprls_core.sv @@
// Frame buffer, position/length counters, line-select machine and timeout
// counter; computes one result per event. Depends on fprls_pkg.
module fprls_core #(
    parameter int unsigned MAX_FRAME = fprls_pkg::MAX_FRAME_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_rx_byte,
    input  logic [15:0]         i_timeout_ticks,
    output fprls_pkg::t_result  o_result
);
    import fprls_pkg::*;

    localparam int unsigned PW   = $clog2(MAX_FRAME + 1);
    localparam int unsigned IW   = $clog2(MAX_FRAME);
    localparam logic [PW-1:0] MAXP = PW'(MAX_FRAME);
    localparam logic [7:0]    MAX8 = 8'(MAX_FRAME);

    logic [7:0]    r_buf [MAX_FRAME];
    logic [7:0]    n_buf [MAX_FRAME];
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_len, n_len;
    logic [1:0]    r_mode, n_mode;
    logic [1:0]    r_pins, n_pins;
    logic [15:0]   r_tick, n_tick;

    logic [PW-1:0] len_clamp;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] rd_idx;
    logic [15:0]   tick_inc;
    logic          tx_valid;
    logic [7:0]    tx_byte;
    t_sel          sel;

    always_comb begin
        if (i_rx_byte > MAX8) begin
            len_clamp = MAXP;
        end else if (i_rx_byte < MIN_LEN) begin
            len_clamp = PW'(MIN_LEN);
        end else begin
            len_clamp = PW'(i_rx_byte);
        end
    end

    assign rd_idx   = r_len - r_pos;
    assign tick_inc = r_tick + 16'd1;

    always_comb begin
        n_buf    = r_buf;
        n_pos    = r_pos;
        n_len    = r_len;
        n_mode   = r_mode;
        n_pins   = r_pins;
        n_tick   = r_tick;
        tx_valid = 1'b0;
        tx_byte  = 8'd0;
        pos_inc  = r_pos;
        sel      = advance_sel(r_mode, r_buf[2] == MASTER_ID);
        unique case (i_kind)
            KIND_RX: begin
                if (r_pos < MAXP) begin
                    n_buf[IW'(r_pos)] = i_rx_byte;
                end
                if (r_pos == PW'(1)) begin
                    n_buf[1] = 8'(len_clamp);
                    n_len    = len_clamp;
                end
                // stay hunting until the start byte sits at the front
                pos_inc = (n_buf[0] == START_BYTE) ? r_pos + PW'(1) : r_pos;
                n_pos   = pos_inc;
                if (pos_inc == n_len) begin
                    sel      = advance_sel(r_mode, n_buf[2] == MASTER_ID);
                    n_mode   = sel.mode;
                    n_pins   = sel.pins;
                    n_tick   = 16'd0;
                    tx_valid = 1'b1;
                    tx_byte  = n_buf[0];
                    n_pos    = pos_inc - PW'(1);
                end
            end
            KIND_TXDONE: begin
                if (r_pos == '0) begin
                    n_mode = sel.mode;
                    n_pins = sel.pins;
                    n_tick = 16'd0;
                end else begin
                    tx_valid = 1'b1;
                    if (r_pos <= r_len && rd_idx < MAXP) begin
                        tx_byte = r_buf[IW'(rd_idx)];
                    end
                    n_pos = r_pos - PW'(1);
                end
            end
            KIND_TICK: begin
                if (r_mode != MODE_IDLE) begin
                    n_tick = tick_inc;
                    if (tick_inc == i_timeout_ticks) begin
                        // load and start the timeout frame
                        n_mode   = sel.mode;
                        n_pins   = sel.pins;
                        n_tick   = 16'd0;
                        n_buf[0] = START_BYTE;
                        n_buf[1] = TIMEOUT_LEN;
                        n_buf[2] = TIMEOUT_ID;
                        n_len    = PW'(TIMEOUT_LEN);
                        n_pos    = PW'(TIMEOUT_LEN) - PW'(1);
                        tx_valid = 1'b1;
                        tx_byte  = START_BYTE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FRAME; i++) begin
                r_buf[i] <= 8'd0;
            end
            r_pos  <= '0;
            r_len  <= PW'(MIN_LEN);
            r_mode <= MODE_IDLE;
            r_pins <= 2'b00;
            r_tick <= 16'd0;
        end else if (i_step) begin
            r_buf  <= n_buf;
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_mode <= n_mode;
            r_pins <= n_pins;
            r_tick <= n_tick;
        end
    end

    assign o_result.tx_valid    = tx_valid;
    assign o_result.tx_byte     = tx_byte;
    assign o_result.line_select = n_pins;
    assign o_result.relay_mode  = n_mode;

endmodule

@@ rtl/framed_packet_relay_line_select.sv @@
// Top level of the framed packet relay: input register, event core, result
// register and register port. Depends on fprls_pkg, fprls_cfg, fprls_core.
//
//   port group   direction  flow control      payload
//   event in     in         i_valid/o_stall   i_kind, i_rx_byte
//   result out   out        o_valid/i_stall   o_tx_valid, o_tx_byte,
//                                             o_line_select, o_relay_mode
//   register     in/out     psel/penable      paddr, pwdata, prdata
//
// Each accepted event yields one result: it waits in the input register, then
// passes through the core into the result register. One event per cycle is
// sustained unless the result stalls; the core state updates on each step.
// Reset is synchronous and clears the frame buffer and all counters at once.
// A stalled result holds the result register; an event in the input register
// then holds too and o_stall rises, so nothing is dropped.
module framed_packet_relay_line_select #(
    parameter int unsigned MAX_FRAME = fprls_pkg::MAX_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_kind,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_tx_valid,
    output logic [7:0]                          o_tx_byte,
    output logic [1:0]                          o_line_select,
    output logic [1:0]                          o_relay_mode,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fprls_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fprls_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fprls_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import fprls_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_rx_byte;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        step;
    logic        in_accept;
    logic [15:0] timeout_ticks;
    t_result     result;

    assign out_free  = !r_out_valid || !i_stall;
    assign step      = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    fprls_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_timeout_ticks (timeout_ticks)
    );

    fprls_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_kind          (r_kind),
        .i_rx_byte       (r_rx_byte),
        .i_timeout_ticks (timeout_ticks),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind    <= i_kind;
            r_rx_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_tx_valid    = r_out.tx_valid;
    assign o_tx_byte     = r_out.tx_byte;
    assign o_line_select = r_out.line_select;
    assign o_relay_mode  = r_out.relay_mode;

`ifndef NO_ASSERTIONS
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_byte == 8'd0)
        else $error("tx byte nonzero without a transmit");

    a_pins_track_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_select == o_relay_mode)
        else $error("line select pins disagree with relay mode");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_kind) && $stable(r_rx_byte))
        else $error("pending event lost while output stalled");
`endif

endmodule

@@ bench/relay_echo_check.sv @@
`timescale 1ns / 1ps
// Result checker for the framed packet relay: mirrors the frame buffer, the
// line-select machine and the timeout counter, and compares results in order.
// Depends on fprls_pkg; instantiated beside the relay by the testbench top.
module relay_echo_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic [1:0]                          i_kind,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic                                o_tx_valid,
    input  logic [7:0]                          o_tx_byte,
    input  logic [1:0]                          o_line_select,
    input  logic [1:0]                          o_relay_mode,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [fprls_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fprls_pkg::CFG_DATA_W-1:0]    pwdata,
    output int                                  fail_count,
    output int                                  pending
);
    import fprls_pkg::*;

    localparam int unsigned FRAME_DEPTH = MAX_FRAME_DEF;
    localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

    logic [7:0]  frame_mem [FRAME_DEPTH];
    logic [3:0]  rx_pos;
    logic [3:0]  frame_len;
    logic [1:0]  sel_mode;
    logic [1:0]  sel_pins;
    logic [15:0] busy_ticks;
    logic [15:0] timeout_limit;

    t_result echo_due [$];
    t_result want_res;
    t_result got_res;
    int      result_idx;

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("%0t ns: result %0d %s: got %0h, want %0h",
                 $time, result_idx, what, got, want);
        fail_count++;
    endtask

    task automatic clear_model();
        int n;
        for (n = 0; n < FRAME_DEPTH; n++) frame_mem[n] = 8'h00;
        rx_pos        = 4'd0;
        frame_len     = 4'(MIN_LEN);
        sel_mode      = MODE_IDLE;
        sel_pins      = 2'b00;
        busy_ticks    = 16'd0;
        timeout_limit = TIMEOUT_RESET;
    endtask

    // Every step of the machine also restarts the tick count.
    task automatic step_line_select();
        busy_ticks = 16'd0;
        case (sel_mode)
            MODE_IDLE: begin
                if (frame_mem[2] == MASTER_ID) begin
                    sel_mode = MODE_ONE;
                    sel_pins = 2'b01;
                end else begin
                    sel_mode = MODE_THREE;
                    sel_pins = 2'b11;
                end
            end
            MODE_ONE: begin
                sel_mode = MODE_IDLE;
                sel_pins = 2'b00;
            end
            MODE_TWO: begin
                sel_mode = MODE_ONE;
                sel_pins = 2'b01;
            end
            default: begin
                sel_mode = MODE_TWO;
                sel_pins = 2'b10;
            end
        endcase
    endtask

    // Echo order runs from the frame start: index is length minus position.
    task automatic pop_echo_byte(output logic [7:0] b);
        logic [3:0] idx;
        idx = frame_len - rx_pos;
        if (rx_pos <= frame_len && idx < FRAME_DEPTH) b = frame_mem[idx];
        else b = 8'h00;
        rx_pos = rx_pos - 4'd1;
    endtask

    task automatic predict_event(input logic [1:0] kind, input logic [7:0] rx,
                                 output t_result r);
        logic [7:0] len;
        logic [7:0] b;
        r = '0;
        b = 8'h00;
        case (kind)
            KIND_RX: begin
                if (rx_pos < FRAME_DEPTH) frame_mem[rx_pos] = rx;
                if (rx_pos == 4'd1) begin
                    len = rx;
                    if (len > FRAME_DEPTH) len = 8'(FRAME_DEPTH);
                    if (len < MIN_LEN) len = MIN_LEN;
                    frame_mem[1] = len;
                    frame_len    = len[3:0];
                end
                // hunt: hold position 0 until the start byte is stored
                if (frame_mem[0] == START_BYTE) rx_pos = rx_pos + 4'd1;
                if (rx_pos == frame_len) begin
                    step_line_select();
                    pop_echo_byte(b);
                    r.tx_valid = 1'b1;
                end
            end
            KIND_TXDONE: begin
                if (rx_pos == 4'd0) begin
                    step_line_select();
                end else begin
                    pop_echo_byte(b);
                    r.tx_valid = 1'b1;
                end
            end
            KIND_TICK: begin
                if (sel_mode != MODE_IDLE) begin
                    busy_ticks = busy_ticks + 16'd1;
                    if (busy_ticks == timeout_limit) begin
                        step_line_select();
                        frame_mem[0] = START_BYTE;
                        frame_mem[1] = TIMEOUT_LEN;
                        frame_mem[2] = TIMEOUT_ID;
                        frame_len    = 4'(TIMEOUT_LEN);
                        rx_pos       = 4'(TIMEOUT_LEN);
                        pop_echo_byte(b);
                        r.tx_valid   = 1'b1;
                        busy_ticks   = 16'd0;
                    end
                end
            end
            default: ;
        endcase
        r.tx_byte     = r.tx_valid ? b : 8'h00;
        r.line_select = sel_pins;
        r.relay_mode  = sel_mode;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            echo_due.delete();
            result_idx = 0;
            fail_count = 0;
            pending   <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
                timeout_limit = pwdata[15:0];
            if (i_valid && !o_stall) begin
                predict_event(i_kind, i_rx_byte, want_res);
                echo_due.push_back(want_res);
            end
            if (o_valid && !i_stall) begin
                got_res.tx_valid    = o_tx_valid;
                got_res.tx_byte     = o_tx_byte;
                got_res.line_select = o_line_select;
                got_res.relay_mode  = o_relay_mode;
                if (echo_due.size() == 0) begin
                    flag_mismatch("arrived with no event pending", got_res.tx_byte, 8'h00);
                end else begin
                    want_res = echo_due.pop_front();
                    if (got_res.tx_valid !== want_res.tx_valid)
                        flag_mismatch("tx_valid", 8'(got_res.tx_valid),
                                      8'(want_res.tx_valid));
                    if (got_res.tx_byte !== want_res.tx_byte)
                        flag_mismatch("tx_byte", got_res.tx_byte, want_res.tx_byte);
                    if (got_res.line_select !== want_res.line_select)
                        flag_mismatch("line_select", 8'(got_res.line_select),
                                      8'(want_res.line_select));
                    if (got_res.relay_mode !== want_res.relay_mode)
                        flag_mismatch("relay_mode", 8'(got_res.relay_mode),
                                      8'(want_res.relay_mode));
                end
                result_idx++;
            end
            pending <= echo_due.size();
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the framed packet relay: clock, reset, event and register
// stimulus, receiver stalls, watchdog and verdict. Depends on fprls_pkg,
// framed_packet_relay_line_select and relay_echo_check.
module tb;
    import fprls_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
    // Longest quiet stretch: worst sender gap or stall run plus a register write.
    localparam int QUIET_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_kind;
    logic [7:0]            i_rx_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_tx_valid;
    logic [7:0]            o_tx_byte;
    logic [1:0]            o_line_select;
    logic [1:0]            o_relay_mode;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int events_sent;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    framed_packet_relay_line_select dut (.*);
    relay_echo_check echo_check (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(negedge i_clk)
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pwrite)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Offer one event after an optional idle gap; return once it is taken.
    task automatic push_event(input logic [1:0] kind, input logic [7:0] rx);
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (o_stall);
        events_sent++;
    endtask

    // Drop valid and wait for every expected transaction to come out.
    task automatic settle_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        settle_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly whole frames with random content and their echo, else noise.
    task automatic random_burst();
        logic [7:0] len_byte;
        logic [7:0] b;
        int         frame_bytes;
        int         n;
        if ($urandom_range(99) < 70) begin
            push_event(KIND_RX, START_BYTE);
            len_byte = ($urandom_range(3) != 0) ? 8'($urandom_range(12))
                                                : 8'($urandom_range(255));
            push_event(KIND_RX, len_byte);
            if (len_byte < MIN_LEN) frame_bytes = int'(MIN_LEN);
            else if (len_byte > MAX_FRAME_DEF) frame_bytes = MAX_FRAME_DEF;
            else frame_bytes = int'(len_byte);
            for (n = 2; n < frame_bytes; n++) begin
                if ($urandom_range(9) == 0) push_event(KIND_TICK, 8'($urandom));
                b = (n == 2 && $urandom_range(1) == 1) ? MASTER_ID : 8'($urandom);
                push_event(KIND_RX, b);
            end
            for (n = 1; n <= frame_bytes; n++) begin
                case ($urandom_range(19))
                    0: push_event(KIND_TICK, 8'($urandom));
                    1: push_event(KIND_RX, 8'($urandom));
                    default: ;
                endcase
                push_event(KIND_TXDONE, 8'($urandom));
            end
            repeat ($urandom_range(6)) push_event(KIND_TICK, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4))
                push_event(2'($urandom_range(3)), 8'($urandom));
        end
    endtask

    initial begin
        int          p;
        int          n;
        int          phase_start;
        logic [15:0] tmo;
        bit          paused;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = KIND_RX;
        i_rx_byte   = 8'h00;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        events_sent = 0;
        paused      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unused kind, idle tick, advance from idle, hunting
        push_event(KIND_NONE, 8'hFF);
        push_event(KIND_TICK, 8'h00);
        push_event(KIND_TXDONE, 8'h00);
        push_event(KIND_RX, 8'h00);
        push_event(KIND_RX, 8'hFF);
        // length 0 and length 1 both raise to 2
        push_event(KIND_RX, START_BYTE);
        push_event(KIND_RX, 8'h00);
        push_event(KIND_TXDONE, 8'h00);
        push_event(KIND_TXDONE, 8'h00);
        push_event(KIND_RX, START_BYTE);
        push_event(KIND_RX, 8'h01);
        push_event(KIND_TXDONE, 8'hFF);
        push_event(KIND_TXDONE, 8'hFF);
        // longest frame with master id, then restart the echo with new bytes
        push_event(KIND_RX, START_BYTE);
        push_event(KIND_RX, 8'hFF);
        push_event(KIND_RX, MASTER_ID);
        for (n = 0; n < 8; n++) push_event(KIND_RX, 8'(n * 37 + 128));
        push_event(KIND_TXDONE, 8'h00);
        push_event(KIND_RX, 8'h5A);
        push_event(KIND_RX, 8'hA5);
        // short timeout: timeout frame, its echo, then another timeout
        write_timeout(16'd2);
        push_event(KIND_TICK, 8'h00);
        push_event(KIND_TICK, 8'h00);
        repeat (3) push_event(KIND_TXDONE, 8'h00);
        push_event(KIND_TICK, 8'h00);
        push_event(KIND_TICK, 8'h00);

        for (p = 0; p < 6; p++) begin
            case (p)
                0:       tmo = 16'd1;
                1:       tmo = 16'hFFFF;
                2:       tmo = 16'd4;
                3:       tmo = 16'd2;
                4:       tmo = 16'd9;
                default: tmo = 16'd3;
            endcase
            write_timeout(tmo);
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default: begin
                    idle_pct  = 29;
                    stall_pct = 29;
                end
            endcase
            phase_start = events_sent;
            while (events_sent - phase_start < 95) begin
                random_burst();
                if (p == 2 && !paused && events_sent - phase_start >= 50) begin
                    settle_results();
                    paused = 1'b1;
                end
            end
        end

        settle_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/fprls_pkg.sv
rtl/fprls_cfg.sv
rtl/fprls_core.sv
rtl/framed_packet_relay_line_select.sv
bench/relay_echo_check.sv
bench/tb.sv
